[hdl/bcd_signed_decimal_alu_macros.svh]
// Assertion helpers for the decimal ALU module.
`ifndef BCD_SIGNED_DECIMAL_ALU_MACROS_SVH
`define BCD_SIGNED_DECIMAL_ALU_MACROS_SVH

// Same-cycle implication, clocked on i_clk, off during reset.
`define BSDA_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, clocked on i_clk, off during reset.
`define BSDA_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/bsda_pkg.sv]
package bsda_pkg;

    localparam int DIGITS_DEF   = 20;
    localparam int NUM_REGS_DEF = 16;

    // Operation codes
    localparam logic [2:0] FN_LOAD = 3'd0;
    localparam logic [2:0] FN_ADD  = 3'd1;
    localparam logic [2:0] FN_SUB  = 3'd2;
    localparam logic [2:0] FN_MUL  = 3'd3;
    localparam logic [2:0] FN_DIV  = 3'd4;
    localparam logic [2:0] FN_READ = 3'd5;

    // Status codes
    localparam logic [1:0] ST_OK  = 2'd0;
    localparam logic [1:0] ST_OVF = 2'd1;
    localparam logic [1:0] ST_DZ  = 2'd2;

    typedef logic [3:0] t_digit;

    typedef struct packed {
        logic [2:0]         func;
        logic signed [31:0] load_value;
        logic [3:0]         src_a;
        logic [3:0]         src_b;
        logic [3:0]         dest;
    } t_in_item;

    typedef struct packed {
        logic [1:0] status;
        logic       negative;
        logic [3:0] digit;
        logic       last;
    } t_out_item;

    // One BCD digit add: returns {carry, digit}
    function automatic logic [4:0] bcd_add(input t_digit x, input t_digit y, input logic c);
        logic [4:0] s;
        s = 5'(x) + 5'(y) + 5'(c);
        if (s >= 5'd10) begin
            return {1'b1, 4'(s - 5'd10)};
        end
        return {1'b0, s[3:0]};
    endfunction

    // One BCD digit subtract: returns {borrow, digit}
    function automatic logic [4:0] bcd_sub(input t_digit x, input t_digit y, input logic b);
        logic [4:0] s;
        s = 5'(y) + 5'(b);
        if (5'(x) >= s) begin
            return {1'b0, 4'(5'(x) - s)};
        end
        return {1'b1, 4'(5'(x) + 5'd10 - s)};
    endfunction

endpackage

[hdl/bcd_signed_decimal_alu.sv]
// Signed decimal register file: NUM_REGS sign-magnitude registers of up to DIGITS BCD
// digits, all positive zero after reset. Each request loads a 32-bit integer, adds,
// subtracts, multiplies or divides two registers into a destination (one result with
// status), or reads a register out one digit per result, most significant first.
// Work runs one digit per cycle through shift registers and a digit memory with one
// read and one write port. A load converts binary to BCD, one bit per cycle, then
// writes back. Add and subtract fetch, compare, add and write back. Multiply adds the
// multiplicand once per unit of each multiplier digit; divide tries up to nine
// subtractions per quotient digit. A read passes an address state and a data state
// for each digit. A new request is taken once the previous one has posted its last
// result to the output register.
`include "bcd_signed_decimal_alu_macros.svh"

module bcd_signed_decimal_alu #(
    parameter int DIGITS   = bsda_pkg::DIGITS_DEF,
    parameter int NUM_REGS = bsda_pkg::NUM_REGS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  bsda_pkg::t_in_item  i_in,
    output logic                o_in_stall,
    output logic                o_out_valid,
    output bsda_pkg::t_out_item o_out,
    input  logic                i_out_stall
);

    localparam int RW = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
    localparam int DW = $clog2(DIGITS);
    localparam int AW = $clog2(NUM_REGS * DIGITS);
    localparam int CW = $clog2(2 * DIGITS + 40);
    localparam int PW = $clog2(DIGITS + 1);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_LOAD   = 4'd1;
    localparam logic [3:0] S_FETCH  = 4'd2;
    localparam logic [3:0] S_CMP    = 4'd3;
    localparam logic [3:0] S_ADD    = 4'd4;
    localparam logic [3:0] S_MSHIFT = 4'd5;
    localparam logic [3:0] S_MADD   = 4'd6;
    localparam logic [3:0] S_DSHIFT = 4'd7;
    localparam logic [3:0] S_DSUB   = 4'd8;
    localparam logic [3:0] S_DCHK   = 4'd9;
    localparam logic [3:0] S_WB     = 4'd10;
    localparam logic [3:0] S_DONE   = 4'd11;
    localparam logic [3:0] S_RMETA  = 4'd12;
    localparam logic [3:0] S_RTOP   = 4'd13;
    localparam logic [3:0] S_RADDR  = 4'd14;
    localparam logic [3:0] S_RDATA  = 4'd15;

    // Register index modulo NUM_REGS by repeated subtraction
    function automatic logic [RW-1:0] reg_mod(input logic [3:0] v);
        logic [6:0] m;
        m = 7'(v);
        for (int k = 0; k < 8; k++) begin
            if (m >= 7'(NUM_REGS)) begin
                m = m - 7'(NUM_REGS);
            end
        end
        return RW'(m);
    endfunction

    // Control
    logic [3:0]    r_state, n_state;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [PW-1:0] r_pos, n_pos;
    logic [3:0]    r_q, n_q;
    logic          r_c, n_c;
    logic          r_ovf, n_ovf;
    logic          r_lt, n_lt;
    logic          r_bnz, n_bnz;
    logic [1:0]    r_st, n_st;
    logic [2:0]    r_func, n_func;
    logic [RW-1:0] r_ia, n_ia, r_ib, n_ib, r_id, n_id;
    logic          r_sa, n_sa, r_sb, n_sb, r_sr, n_sr;
    logic [DW-1:0] r_top, n_top;
    logic          r_nz, n_nz;
    logic [31:0]   r_lv, n_lv;

    // Digit shift registers
    bsda_pkg::t_digit r_a [DIGITS];
    bsda_pkg::t_digit n_a [DIGITS];
    bsda_pkg::t_digit r_b [DIGITS];
    bsda_pkg::t_digit n_b [DIGITS];
    bsda_pkg::t_digit r_r [DIGITS];
    bsda_pkg::t_digit n_r [DIGITS];
    bsda_pkg::t_digit r_rem [DIGITS+1];
    bsda_pkg::t_digit n_rem [DIGITS+1];
    bsda_pkg::t_digit r_t [DIGITS+1];
    bsda_pkg::t_digit n_t [DIGITS+1];
    bsda_pkg::t_digit adj [DIGITS];

    // Register file storage
    bsda_pkg::t_digit  r_mem [NUM_REGS*DIGITS];
    logic [DW:0]       r_meta [NUM_REGS];
    logic [NUM_REGS-1:0] r_vld;
    bsda_pkg::t_digit  r_rdig;
    logic [DW:0]       r_rmeta;
    logic              r_rvld;

    logic [RW-1:0]     rd_reg;
    logic [DW-1:0]     rd_dig;
    logic [AW-1:0]     rd_addr, wr_addr;
    logic              wr_en, meta_we;
    logic [DW:0]       meta_wd;
    bsda_pkg::t_digit  eff_dig;
    logic              eff_sign;
    logic [DW-1:0]     eff_top;
    logic              bnz_full;
    logic [4:0]        dr;
    bsda_pkg::t_digit  bdig;
    logic [31:0]       lvu;
    logic [DW-1:0]     top_fin;

    // Output register
    logic                r_out_vld;
    bsda_pkg::t_out_item r_out, out_d;
    logic                out_wr, out_free, in_acc;

    assign in_acc      = i_in_valid && !o_in_stall;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_vld;
    assign o_out       = r_out;
    assign out_free    = !r_out_vld || !i_out_stall;

    assign eff_dig  = r_rvld ? r_rdig : 4'd0;
    assign eff_sign = r_rvld & r_rmeta[DW];
    assign eff_top  = r_rvld ? r_rmeta[DW-1:0] : '0;
    assign bnz_full = r_bnz | (eff_dig != 4'd0);
    assign lvu      = i_in.load_value;
    assign top_fin  = (r_r[0] != 4'd0) ? DW'(r_cnt) : r_top;

    assign rd_addr = AW'(rd_reg) * AW'(DIGITS) + AW'(rd_dig);
    assign wr_addr = AW'(r_id) * AW'(DIGITS) + AW'(r_cnt[DW-1:0]);

    // Sequencer
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_pos   = r_pos;
        n_q     = r_q;
        n_c     = r_c;
        n_ovf   = r_ovf;
        n_lt    = r_lt;
        n_bnz   = r_bnz;
        n_st    = r_st;
        n_func  = r_func;
        n_ia    = r_ia;
        n_ib    = r_ib;
        n_id    = r_id;
        n_sa    = r_sa;
        n_sb    = r_sb;
        n_sr    = r_sr;
        n_top   = r_top;
        n_nz    = r_nz;
        n_lv    = r_lv;
        n_a     = r_a;
        n_b     = r_b;
        n_r     = r_r;
        n_rem   = r_rem;
        n_t     = r_t;
        out_wr  = 1'b0;
        out_d   = '0;
        wr_en   = 1'b0;
        meta_we = 1'b0;
        meta_wd = '0;
        rd_reg  = r_ia;
        rd_dig  = '0;
        dr      = '0;
        bdig    = '0;
        for (int i = 0; i < DIGITS; i++) begin
            adj[i] = (r_r[i] >= 4'd5) ? 4'(r_r[i] + 4'd3) : r_r[i];
        end

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_func = i_in.func;
                    n_ia   = reg_mod(i_in.src_a);
                    n_ib   = reg_mod(i_in.src_b);
                    n_id   = reg_mod(i_in.dest);
                    n_cnt  = '0;
                    n_pos  = '0;
                    n_c    = 1'b0;
                    n_ovf  = 1'b0;
                    n_lt   = 1'b0;
                    n_bnz  = 1'b0;
                    n_st   = bsda_pkg::ST_OK;
                    n_top  = '0;
                    n_nz   = 1'b0;
                    n_sr   = lvu[31];
                    n_lv   = lvu[31] ? (32'd0 - lvu) : lvu;
                    for (int i = 0; i < DIGITS; i++) begin
                        n_r[i] = 4'd0;
                    end
                    unique case (i_in.func) inside
                        bsda_pkg::FN_LOAD: n_state = S_LOAD;
                        bsda_pkg::FN_ADD, bsda_pkg::FN_SUB,
                        bsda_pkg::FN_MUL, bsda_pkg::FN_DIV: n_state = S_FETCH;
                        bsda_pkg::FN_READ: n_state = S_RMETA;
                        default: n_state = S_DONE;
                    endcase
                end
            end

            // Shift one binary bit into the BCD digits per cycle
            S_LOAD: begin
                n_r[0] = {adj[0][2:0], r_lv[31]};
                for (int i = 1; i < DIGITS; i++) begin
                    n_r[i] = {adj[i][2:0], adj[i-1][3]};
                end
                if (adj[DIGITS-1][3]) begin
                    n_ovf = 1'b1;
                end
                n_lv = {r_lv[30:0], 1'b0};
                if (r_cnt == CW'(31)) begin
                    n_cnt   = '0;
                    n_state = S_WB;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end

            // Stream both operands out of memory, units digit first
            S_FETCH: begin
                if (r_cnt < CW'(DIGITS)) begin
                    rd_reg = r_ia;
                    rd_dig = DW'(r_cnt);
                end else begin
                    rd_reg = r_ib;
                    if (r_cnt < CW'(2 * DIGITS)) begin
                        rd_dig = DW'(r_cnt - CW'(DIGITS));
                    end
                end
                if (r_cnt >= CW'(1) && r_cnt <= CW'(DIGITS)) begin
                    for (int i = 0; i < DIGITS - 1; i++) begin
                        n_a[i] = r_a[i+1];
                    end
                    n_a[DIGITS-1] = eff_dig;
                end
                if (r_cnt > CW'(DIGITS)) begin
                    for (int i = 0; i < DIGITS - 1; i++) begin
                        n_b[i] = r_b[i+1];
                    end
                    n_b[DIGITS-1] = eff_dig;
                    n_bnz = bnz_full;
                end
                if (r_cnt == CW'(1)) begin
                    n_sa = eff_sign;
                end
                if (r_cnt == CW'(DIGITS + 1)) begin
                    n_sb = eff_sign;
                end
                if (r_cnt == CW'(2 * DIGITS)) begin
                    n_cnt = '0;
                    for (int i = 0; i < DIGITS + 1; i++) begin
                        n_rem[i] = 4'd0;
                    end
                    unique case (r_func) inside
                        bsda_pkg::FN_ADD: n_state = S_CMP;
                        bsda_pkg::FN_SUB: begin
                            n_sb    = ~r_sb;
                            n_state = S_CMP;
                        end
                        bsda_pkg::FN_MUL: n_state = S_MSHIFT;
                        default: begin
                            if (!bnz_full) begin
                                n_st    = bsda_pkg::ST_DZ;
                                n_state = S_DONE;
                            end else begin
                                n_state = S_DSHIFT;
                            end
                        end
                    endcase
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end

            // Compare magnitudes; the most significant difference wins
            S_CMP: begin
                if (r_a[0] > r_b[0]) begin
                    n_lt = 1'b0;
                end else if (r_a[0] < r_b[0]) begin
                    n_lt = 1'b1;
                end
                for (int i = 0; i < DIGITS - 1; i++) begin
                    n_a[i] = r_a[i+1];
                    n_b[i] = r_b[i+1];
                end
                n_a[DIGITS-1] = r_a[0];
                n_b[DIGITS-1] = r_b[0];
                if (r_cnt == CW'(DIGITS - 1)) begin
                    n_cnt   = '0;
                    n_c     = 1'b0;
                    n_state = S_ADD;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end

            // Signed add or subtract, one digit per cycle
            S_ADD: begin
                if (r_sa == r_sb) begin
                    dr = bsda_pkg::bcd_add(r_a[0], r_b[0], r_c);
                end else if (!r_lt) begin
                    dr = bsda_pkg::bcd_sub(r_a[0], r_b[0], r_c);
                end else begin
                    dr = bsda_pkg::bcd_sub(r_b[0], r_a[0], r_c);
                end
                n_c = dr[4];
                for (int i = 0; i < DIGITS - 1; i++) begin
                    n_a[i] = r_a[i+1];
                    n_b[i] = r_b[i+1];
                    n_r[i] = r_r[i+1];
                end
                n_a[DIGITS-1] = r_a[0];
                n_b[DIGITS-1] = r_b[0];
                n_r[DIGITS-1] = dr[3:0];
                if (r_cnt == CW'(DIGITS - 1)) begin
                    if (r_sa == r_sb && dr[4]) begin
                        n_ovf = 1'b1;
                    end
                    n_sr    = (r_sa == r_sb || !r_lt) ? r_sa : r_sb;
                    n_cnt   = '0;
                    n_state = S_WB;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end

            // Multiply: scale product by ten, take next multiplier digit
            S_MSHIFT: begin
                if (r_r[DIGITS-1] != 4'd0) begin
                    n_ovf = 1'b1;
                end
                n_r[0] = 4'd0;
                n_b[0] = 4'd0;
                for (int i = 1; i < DIGITS; i++) begin
                    n_r[i] = r_r[i-1];
                    n_b[i] = r_b[i-1];
                end
                n_q   = r_b[DIGITS-1];
                n_cnt = '0;
                n_c   = 1'b0;
                if (r_b[DIGITS-1] != 4'd0) begin
                    n_state = S_MADD;
                end else if (r_pos == PW'(DIGITS - 1)) begin
                    n_sr    = r_sa ^ r_sb;
                    n_state = S_WB;
                end else begin
                    n_pos = r_pos + 1'b1;
                end
            end

            // Add the multiplicand into the product once
            S_MADD: begin
                dr  = bsda_pkg::bcd_add(r_r[0], r_a[0], r_c);
                n_c = dr[4];
                for (int i = 0; i < DIGITS - 1; i++) begin
                    n_a[i] = r_a[i+1];
                    n_r[i] = r_r[i+1];
                end
                n_a[DIGITS-1] = r_a[0];
                n_r[DIGITS-1] = dr[3:0];
                if (r_cnt == CW'(DIGITS - 1)) begin
                    if (dr[4]) begin
                        n_ovf = 1'b1;
                    end
                    n_c   = 1'b0;
                    n_cnt = '0;
                    n_q   = r_q - 1'b1;
                    if (r_q == 4'd1) begin
                        if (r_pos == PW'(DIGITS - 1)) begin
                            n_sr    = r_sa ^ r_sb;
                            n_state = S_WB;
                        end else begin
                            n_pos   = r_pos + 1'b1;
                            n_state = S_MSHIFT;
                        end
                    end
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end

            // Divide: bring the next dividend digit into the remainder
            S_DSHIFT: begin
                n_rem[0] = r_a[DIGITS-1];
                for (int i = 1; i < DIGITS + 1; i++) begin
                    n_rem[i] = r_rem[i-1];
                end
                n_a[0] = 4'd0;
                for (int i = 1; i < DIGITS; i++) begin
                    n_a[i] = r_a[i-1];
                end
                n_q     = 4'd0;
                n_cnt   = '0;
                n_c     = 1'b0;
                n_state = S_DSUB;
            end

            // Trial subtraction of the divisor from the remainder
            S_DSUB: begin
                bdig = (r_cnt < CW'(DIGITS)) ? r_b[0] : 4'd0;
                dr   = bsda_pkg::bcd_sub(r_rem[0], bdig, r_c);
                n_c  = dr[4];
                for (int i = 0; i < DIGITS; i++) begin
                    n_t[i]   = r_t[i+1];
                    n_rem[i] = r_rem[i+1];
                end
                n_t[DIGITS]   = dr[3:0];
                n_rem[DIGITS] = r_rem[0];
                if (r_cnt < CW'(DIGITS)) begin
                    for (int i = 0; i < DIGITS - 1; i++) begin
                        n_b[i] = r_b[i+1];
                    end
                    n_b[DIGITS-1] = r_b[0];
                end
                if (r_cnt == CW'(DIGITS)) begin
                    n_state = S_DCHK;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end

            // Keep the difference if no borrow; retire the quotient digit
            S_DCHK: begin
                if (!r_c && r_q != 4'd8) begin
                    n_rem   = r_t;
                    n_q     = r_q + 1'b1;
                    n_cnt   = '0;
                    n_c     = 1'b0;
                    n_state = S_DSUB;
                end else begin
                    if (!r_c) begin
                        n_rem = r_t;
                        n_a[0] = 4'd9;
                    end else begin
                        n_a[0] = r_q;
                    end
                    if (r_pos == PW'(DIGITS - 1)) begin
                        n_r     = n_a;
                        n_sr    = r_sa ^ r_sb;
                        n_cnt   = '0;
                        n_state = S_WB;
                    end else begin
                        n_pos   = r_pos + 1'b1;
                        n_state = S_DSHIFT;
                    end
                end
            end

            // Write the result digits unless overflow was flagged, tracking the top nonzero digit
            S_WB: begin
                if (r_ovf) begin
                    n_st    = bsda_pkg::ST_OVF;
                    n_state = S_DONE;
                end else begin
                    wr_en = 1'b1;
                    for (int i = 0; i < DIGITS - 1; i++) begin
                        n_r[i] = r_r[i+1];
                    end
                    n_r[DIGITS-1] = r_r[0];
                    n_top = top_fin;
                    if (r_r[0] != 4'd0) begin
                        n_nz = 1'b1;
                    end
                    if (r_cnt == CW'(DIGITS - 1)) begin
                        meta_we = 1'b1;
                        meta_wd = {(r_nz || r_r[0] != 4'd0) ? r_sr : 1'b0, top_fin};
                        n_state = S_DONE;
                    end else begin
                        n_cnt = r_cnt + 1'b1;
                    end
                end
            end

            S_DONE: begin
                if (out_free) begin
                    out_wr         = 1'b1;
                    out_d.status   = r_st;
                    out_d.negative = 1'b0;
                    out_d.digit    = 4'd0;
                    out_d.last     = 1'b1;
                    n_state        = S_IDLE;
                end
            end

            S_RMETA: n_state = S_RTOP;

            S_RTOP: begin
                n_cnt   = CW'(eff_top);
                n_sa    = eff_sign;
                n_state = S_RADDR;
            end

            S_RADDR: begin
                rd_dig  = DW'(r_cnt);
                n_state = S_RDATA;
            end

            // Post one digit, most significant first
            S_RDATA: begin
                rd_dig = DW'(r_cnt);
                if (out_free) begin
                    out_wr         = 1'b1;
                    out_d.status   = bsda_pkg::ST_OK;
                    out_d.negative = r_sa;
                    out_d.digit    = eff_dig;
                    out_d.last     = (r_cnt == '0);
                    if (r_cnt == '0) begin
                        n_state = S_IDLE;
                    end else begin
                        n_cnt   = r_cnt - 1'b1;
                        n_state = S_RADDR;
                    end
                end
            end

            default: n_state = S_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_out_vld <= 1'b0;
            r_vld     <= '0;
        end else begin
            r_state <= n_state;
            if (out_wr) begin
                r_out_vld <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
            if (meta_we) begin
                r_vld[r_id] <= 1'b1;
            end
        end
    end

    // Datapath registers and storage
    always_ff @(posedge i_clk) begin
        r_cnt  <= n_cnt;
        r_pos  <= n_pos;
        r_q    <= n_q;
        r_c    <= n_c;
        r_ovf  <= n_ovf;
        r_lt   <= n_lt;
        r_bnz  <= n_bnz;
        r_st   <= n_st;
        r_func <= n_func;
        r_ia   <= n_ia;
        r_ib   <= n_ib;
        r_id   <= n_id;
        r_sa   <= n_sa;
        r_sb   <= n_sb;
        r_sr   <= n_sr;
        r_top  <= n_top;
        r_nz   <= n_nz;
        r_lv   <= n_lv;
        r_a    <= n_a;
        r_b    <= n_b;
        r_r    <= n_r;
        r_rem  <= n_rem;
        r_t    <= n_t;
        if (out_wr) begin
            r_out <= out_d;
        end
        if (wr_en) begin
            r_mem[wr_addr] <= r_r[0];
        end
        if (meta_we) begin
            r_meta[r_id] <= meta_wd;
        end
        r_rdig  <= r_mem[rd_addr];
        r_rmeta <= r_meta[rd_reg];
        r_rvld  <= r_vld[rd_reg];
    end

    `BSDA_ASSERT_NXT(a_busy_after_accept, in_acc, o_in_stall, "request accepted but not busy")
    `BSDA_ASSERT_IMP(a_no_write_on_ovf, wr_en, !r_ovf && r_state == S_WB, "write despite overflow")
    `BSDA_ASSERT_IMP(a_read_digit_ok, o_out_valid && !o_out.last, o_out.status == bsda_pkg::ST_OK && o_out.digit <= 4'd9, "bad read digit result")

endmodule
